// ===== rtl/gbpm_pkg.sv =====
package gbpm_pkg;

	localparam int MAX_DIM_DEF = 64;
	localparam logic [6:0] DIM_RESET = 7'd21;

	localparam logic [2:0] CODE_OPEN   = 3'd0;
	localparam logic [2:0] CODE_WALL   = 3'd1;
	localparam logic [2:0] CODE_START  = 3'd2;
	localparam logic [2:0] CODE_FINISH = 3'd3;
	localparam logic [2:0] CODE_PATH   = 3'd4;

	localparam logic [2:0] ADDR_ROWS = 3'd0;
	localparam logic [2:0] ADDR_COLS = 3'd4;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_SOLVE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_UNREACH = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		RS_CMD,
		RS_SCAN,
		RS_NB,
		RS_TR
	} rsel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_WAIT,
		S_SCAN,
		S_SCAN_END,
		S_CHECK,
		S_CLEAR,
		S_SEED,
		S_POP,
		S_POP_WAIT,
		S_NB,
		S_NB_EV,
		S_TR_CHK,
		S_TR_EV
	} state_t;

	typedef struct packed {
		rsel_t   rsel;
		logic    grid_wr_cmd;
		logic    scan_init;
		logic    scan_step;
		logic    clr_init;
		logic    clr_step;
		logic    seed;
		logic    pop_issue;
		logic    pop_take;
		logic    nb_next;
		logic    nb_eval;
		logic    tr_init;
		logic    tr_eval;
		logic    res_valid;
		logic    res_read;
		status_t res_status;
	} ctrl_t;

	typedef struct packed {
		logic addr_bad;
		logic scan_last;
		logic have_both;
		logic clr_last;
		logic q_empty;
		logic found;
		logic nb_in;
		logic k_last;
		logic nb_hit;
		logic tr_done;
	} stat_t;

endpackage

// ===== rtl/grid_bfs_path_marker_unit.sv =====
// Grid path marker. A write or a read command, or an unused command, is taken when start is
// high and busy is low; a write answers in the next cycle, so writes run one per cycle, and an
// in-range read answers after the S_RD_WAIT state, from the registered memory output, holding
// busy high while it waits. A solve holds busy high through the start/finish scan and check,
// the clearing of the seen-mark memory, one entry at a time (4**clog2(MAX_DIM) entries,
// MAX_DIM*MAX_DIM at the default), the seed, the search that dequeues each cell and looks at
// its neighbours, and the trace back to the start; each step is paced by the one read address
// that the cell memories share. Each result shows on read_code and status for exactly one
// cycle with done high, and the receiver cannot hold it off.
module grid_bfs_path_marker_unit #(
	parameter int MAX_DIM = gbpm_pkg::MAX_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [5:0]  row,
	input  logic [5:0]  col,
	input  logic [2:0]  cell_code,
	output logic        done,
	output logic [2:0]  read_code,
	output logic [1:0]  status
);

	logic [6:0]      rows_q, cols_q;
	gbpm_pkg::ctrl_t ctrl;
	gbpm_pkg::stat_t stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= gbpm_pkg::DIM_RESET;
			cols_q <= gbpm_pkg::DIM_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == gbpm_pkg::ADDR_COLS[2]) begin
				cols_q <= pwdata[6:0];
			end else begin
				rows_q <= pwdata[6:0];
			end
		end
	end

	assign prdata = (paddr[2] == gbpm_pkg::ADDR_ROWS[2]) ? {25'd0, rows_q} : {25'd0, cols_q};

	gbpm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.busy    (busy),
		.ctrl    (ctrl)
	);

	gbpm_dp #(.MAX_DIM(MAX_DIM)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid_rows (rows_q),
		.grid_cols (cols_q),
		.row       (row),
		.col       (col),
		.cell_code (cell_code),
		.ctrl      (ctrl),
		.stat      (stat),
		.done      (done),
		.read_code (read_code),
		.status    (status)
	);

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	a_solve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == gbpm_pkg::CMD_SOLVE) |=> busy)
		else $error("solve did not raise busy");

	a_range_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == gbpm_pkg::ST_RANGE) |->
			$past(start && !busy && (command == gbpm_pkg::CMD_WRITE
				|| command == gbpm_pkg::CMD_READ)))
		else $error("range status without a cell command");

	a_code_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && read_code != 3'd0) |-> $past(busy))
		else $error("read code on a word that was not a read");

endmodule

// ===== rtl/gbpm_ram.sv =====
module gbpm_ram #(
	parameter int W = 1,
	parameter int D = 2
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/gbpm_ctrl.sv =====
module gbpm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      command,
	input  gbpm_pkg::stat_t stat,
	output logic            busy,
	output gbpm_pkg::ctrl_t ctrl
);

	gbpm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbpm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		ctrl            = '0;
		ctrl.rsel       = gbpm_pkg::RS_CMD;
		ctrl.res_status = gbpm_pkg::ST_OK;
		unique case (state_q)
			gbpm_pkg::S_IDLE: begin
				if (start) begin
					case (gbpm_pkg::cmd_t'(command))
						gbpm_pkg::CMD_WRITE: begin
							ctrl.res_valid = 1'b1;
							if (stat.addr_bad) begin
								ctrl.res_status = gbpm_pkg::ST_RANGE;
							end else begin
								ctrl.grid_wr_cmd = 1'b1;
							end
						end
						gbpm_pkg::CMD_READ: begin
							if (stat.addr_bad) begin
								ctrl.res_valid  = 1'b1;
								ctrl.res_status = gbpm_pkg::ST_RANGE;
							end else begin
								state_d = gbpm_pkg::S_RD_WAIT;
							end
						end
						gbpm_pkg::CMD_SOLVE: begin
							ctrl.scan_init = 1'b1;
							state_d        = gbpm_pkg::S_SCAN;
						end
						default: begin
							ctrl.res_valid = 1'b1;
						end
					endcase
				end
			end
			gbpm_pkg::S_RD_WAIT: begin
				ctrl.res_valid = 1'b1;
				ctrl.res_read  = 1'b1;
				state_d        = gbpm_pkg::S_IDLE;
			end
			gbpm_pkg::S_SCAN: begin
				ctrl.rsel      = gbpm_pkg::RS_SCAN;
				ctrl.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = gbpm_pkg::S_SCAN_END;
				end
			end
			gbpm_pkg::S_SCAN_END: begin
				state_d = gbpm_pkg::S_CHECK;
			end
			gbpm_pkg::S_CHECK: begin
				if (!stat.have_both) begin
					ctrl.res_valid  = 1'b1;
					ctrl.res_status = gbpm_pkg::ST_MISSING;
					state_d         = gbpm_pkg::S_IDLE;
				end else begin
					ctrl.clr_init = 1'b1;
					state_d       = gbpm_pkg::S_CLEAR;
				end
			end
			gbpm_pkg::S_CLEAR: begin
				ctrl.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = gbpm_pkg::S_SEED;
				end
			end
			gbpm_pkg::S_SEED: begin
				ctrl.seed = 1'b1;
				state_d   = gbpm_pkg::S_POP;
			end
			gbpm_pkg::S_POP: begin
				if (stat.found) begin
					ctrl.tr_init = 1'b1;
					state_d      = gbpm_pkg::S_TR_CHK;
				end else if (stat.q_empty) begin
					ctrl.res_valid  = 1'b1;
					ctrl.res_status = gbpm_pkg::ST_UNREACH;
					state_d         = gbpm_pkg::S_IDLE;
				end else begin
					ctrl.pop_issue = 1'b1;
					state_d        = gbpm_pkg::S_POP_WAIT;
				end
			end
			gbpm_pkg::S_POP_WAIT: begin
				ctrl.pop_take = 1'b1;
				state_d       = gbpm_pkg::S_NB;
			end
			gbpm_pkg::S_NB: begin
				ctrl.rsel = gbpm_pkg::RS_NB;
				if (stat.nb_in) begin
					state_d = gbpm_pkg::S_NB_EV;
				end else if (stat.k_last) begin
					state_d = gbpm_pkg::S_POP;
				end else begin
					ctrl.nb_next = 1'b1;
				end
			end
			gbpm_pkg::S_NB_EV: begin
				ctrl.nb_eval = 1'b1;
				if (stat.nb_hit || stat.k_last) begin
					state_d = gbpm_pkg::S_POP;
				end else begin
					state_d = gbpm_pkg::S_NB;
				end
			end
			gbpm_pkg::S_TR_CHK: begin
				ctrl.rsel = gbpm_pkg::RS_TR;
				if (stat.tr_done) begin
					ctrl.res_valid = 1'b1;
					state_d        = gbpm_pkg::S_IDLE;
				end else begin
					state_d = gbpm_pkg::S_TR_EV;
				end
			end
			gbpm_pkg::S_TR_EV: begin
				ctrl.tr_eval = 1'b1;
				state_d      = gbpm_pkg::S_TR_CHK;
			end
			default: begin
				state_d = gbpm_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != gbpm_pkg::S_IDLE);

endmodule

// ===== rtl/gbpm_dp.sv =====
module gbpm_dp #(
	parameter int MAX_DIM = gbpm_pkg::MAX_DIM_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [6:0]      grid_rows,
	input  logic [6:0]      grid_cols,
	input  logic [5:0]      row,
	input  logic [5:0]      col,
	input  logic [2:0]      cell_code,
	input  gbpm_pkg::ctrl_t ctrl,
	output gbpm_pkg::stat_t stat,
	output logic            done,
	output logic [2:0]      read_code,
	output logic [1:0]      status
);

	localparam int AW    = $clog2(MAX_DIM);
	localparam int IW    = 2 * AW;
	localparam int DEPTH = 1 << IW;
	localparam int DW    = AW + 1;
	localparam int QW    = IW + 1;

	logic [DW-1:0] rows_eff, cols_eff;

	always_comb begin
		if (grid_rows == '0) begin
			rows_eff = DW'(1);
		end else if (int'(grid_rows) > MAX_DIM) begin
			rows_eff = DW'(MAX_DIM);
		end else begin
			rows_eff = DW'(grid_rows);
		end
		if (grid_cols == '0) begin
			cols_eff = DW'(1);
		end else if (int'(grid_cols) > MAX_DIM) begin
			cols_eff = DW'(MAX_DIM);
		end else begin
			cols_eff = DW'(grid_cols);
		end
	end

	logic [IW-1:0] cmd_idx;
	assign cmd_idx = {AW'(row), AW'(col)};

	// memories
	logic          grid_we;
	logic [IW-1:0] grid_waddr;
	logic [2:0]    grid_wdata;
	logic [IW-1:0] raddr;
	logic [2:0]    grid_rd;
	logic          seen_we;
	logic [IW-1:0] seen_waddr;
	logic          seen_wdata;
	logic          seen_rd;
	logic          par_we;
	logic [1:0]    par_rd;
	logic          q_we;
	logic [IW-1:0] q_waddr;
	logic [IW-1:0] q_wdata;
	logic [IW-1:0] q_rd;

	// registers
	logic [AW-1:0] scan_r_q, scan_c_q;
	logic [IW-1:0] scan_idx_s1;
	logic          scan_vld_s1;
	logic [IW-1:0] start_q, finish_q;
	logic          start_ok_q, finish_ok_q;
	logic [IW-1:0] clr_q;
	logic [QW-1:0] head_q, tail_q;
	logic          found_q;
	logic [IW-1:0] cur_q;
	gbpm_pkg::dir_t k_q;
	logic [IW-1:0] tcur_q;
	logic          done_q;
	logic [1:0]    status_q;
	logic [2:0]    read_code_q;

	// neighbour of the current cell in direction k
	logic [AW-1:0] cr, cc;
	logic [IW-1:0] nidx;
	logic          nb_in;
	logic          nb_take;

	assign cr = cur_q[IW-1:AW];
	assign cc = cur_q[AW-1:0];

	always_comb begin
		case (k_q)
			gbpm_pkg::DIR_UP: begin
				nb_in = (cr != '0);
				nidx  = {cr - AW'(1), cc};
			end
			gbpm_pkg::DIR_DOWN: begin
				nb_in = ((DW'(cr) + DW'(1)) < rows_eff);
				nidx  = {cr + AW'(1), cc};
			end
			gbpm_pkg::DIR_LEFT: begin
				nb_in = (cc != '0);
				nidx  = {cr, cc - AW'(1)};
			end
			default: begin
				nb_in = ((DW'(cc) + DW'(1)) < cols_eff);
				nidx  = {cr, cc + AW'(1)};
			end
		endcase
	end

	assign nb_take = !seen_rd && (grid_rd != gbpm_pkg::CODE_WALL);

	// parent of the trace cell
	logic [AW-1:0] tr_r, tr_c;
	logic [IW-1:0] tpar;

	assign tr_r = tcur_q[IW-1:AW];
	assign tr_c = tcur_q[AW-1:0];

	always_comb begin
		case (gbpm_pkg::dir_t'(par_rd))
			gbpm_pkg::DIR_UP:   tpar = {tr_r + AW'(1), tr_c};
			gbpm_pkg::DIR_DOWN: tpar = {tr_r - AW'(1), tr_c};
			gbpm_pkg::DIR_LEFT: tpar = {tr_r, tr_c + AW'(1)};
			default:            tpar = {tr_r, tr_c - AW'(1)};
		endcase
	end

	// read address
	always_comb begin
		case (ctrl.rsel)
			gbpm_pkg::RS_SCAN: raddr = {scan_r_q, scan_c_q};
			gbpm_pkg::RS_NB:   raddr = nidx;
			gbpm_pkg::RS_TR:   raddr = tcur_q;
			default:           raddr = cmd_idx;
		endcase
	end

	// write ports
	always_comb begin
		grid_we    = 1'b0;
		grid_waddr = cmd_idx;
		grid_wdata = cell_code;
		if (ctrl.grid_wr_cmd) begin
			grid_we = 1'b1;
		end else if (ctrl.tr_eval && (tcur_q != finish_q)
				&& (grid_rd == gbpm_pkg::CODE_OPEN)) begin
			grid_we    = 1'b1;
			grid_waddr = tcur_q;
			grid_wdata = gbpm_pkg::CODE_PATH;
		end

		seen_we    = 1'b0;
		seen_waddr = clr_q;
		seen_wdata = 1'b0;
		if (ctrl.clr_step) begin
			seen_we = 1'b1;
		end else if (ctrl.seed) begin
			seen_we    = 1'b1;
			seen_waddr = start_q;
			seen_wdata = 1'b1;
		end else if (ctrl.nb_eval && nb_take) begin
			seen_we    = 1'b1;
			seen_waddr = nidx;
			seen_wdata = 1'b1;
		end

		par_we = ctrl.nb_eval && nb_take;

		q_we    = 1'b0;
		q_waddr = tail_q[IW-1:0];
		q_wdata = nidx;
		if (ctrl.seed) begin
			q_we    = 1'b1;
			q_waddr = '0;
			q_wdata = start_q;
		end else if (ctrl.nb_eval && nb_take) begin
			q_we = 1'b1;
		end
	end

	gbpm_ram #(.W(3), .D(DEPTH)) u_grid (
		.clk   (clk),
		.we    (grid_we),
		.waddr (grid_waddr),
		.wdata (grid_wdata),
		.raddr (raddr),
		.rdata (grid_rd)
	);

	gbpm_ram #(.W(1), .D(DEPTH)) u_seen (
		.clk   (clk),
		.we    (seen_we),
		.waddr (seen_waddr),
		.wdata (seen_wdata),
		.raddr (raddr),
		.rdata (seen_rd)
	);

	gbpm_ram #(.W(2), .D(DEPTH)) u_parent (
		.clk   (clk),
		.we    (par_we),
		.waddr (nidx),
		.wdata (k_q),
		.raddr (raddr),
		.rdata (par_rd)
	);

	gbpm_ram #(.W(IW), .D(DEPTH)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (head_q[IW-1:0]),
		.rdata (q_rd)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_s1 <= 1'b0;
			start_ok_q  <= 1'b0;
			finish_ok_q <= 1'b0;
			found_q     <= 1'b0;
			done_q      <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
		end else begin
			scan_vld_s1 <= ctrl.scan_step;
			done_q      <= ctrl.res_valid;
			if (ctrl.scan_init) begin
				start_ok_q  <= 1'b0;
				finish_ok_q <= 1'b0;
			end else if (scan_vld_s1) begin
				if (grid_rd == gbpm_pkg::CODE_START) begin
					start_ok_q <= 1'b1;
				end else if (grid_rd == gbpm_pkg::CODE_FINISH) begin
					finish_ok_q <= 1'b1;
				end
			end
			if (ctrl.seed) begin
				head_q  <= '0;
				tail_q  <= QW'(1);
				found_q <= 1'b0;
			end else begin
				if (ctrl.pop_issue) begin
					head_q <= head_q + QW'(1);
				end
				if (ctrl.nb_eval && nb_take) begin
					tail_q <= tail_q + QW'(1);
					if (nidx == finish_q) begin
						found_q <= 1'b1;
					end
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctrl.scan_init) begin
			scan_r_q <= '0;
			scan_c_q <= '0;
		end else if (ctrl.scan_step) begin
			if ((DW'(scan_c_q) + DW'(1)) == cols_eff) begin
				scan_c_q <= '0;
				scan_r_q <= scan_r_q + AW'(1);
			end else begin
				scan_c_q <= scan_c_q + AW'(1);
			end
		end
		scan_idx_s1 <= {scan_r_q, scan_c_q};
		if (scan_vld_s1 && !ctrl.scan_init) begin
			if (grid_rd == gbpm_pkg::CODE_START) begin
				start_q <= scan_idx_s1;
			end else if (grid_rd == gbpm_pkg::CODE_FINISH) begin
				finish_q <= scan_idx_s1;
			end
		end
		if (ctrl.clr_init) begin
			clr_q <= '0;
		end else if (ctrl.clr_step) begin
			clr_q <= clr_q + IW'(1);
		end
		if (ctrl.pop_take) begin
			cur_q <= q_rd;
			k_q   <= gbpm_pkg::DIR_UP;
		end else if (ctrl.nb_next || ctrl.nb_eval) begin
			k_q <= gbpm_pkg::dir_t'(k_q + 2'd1);
		end
		if (ctrl.tr_init) begin
			tcur_q <= finish_q;
		end else if (ctrl.tr_eval) begin
			tcur_q <= tpar;
		end
		if (ctrl.res_valid) begin
			status_q    <= ctrl.res_status;
			read_code_q <= ctrl.res_read ? grid_rd : 3'd0;
		end
	end

	assign stat.addr_bad  = (int'(row) >= int'(rows_eff)) || (int'(col) >= int'(cols_eff));
	assign stat.scan_last = ((DW'(scan_r_q) + DW'(1)) == rows_eff)
		&& ((DW'(scan_c_q) + DW'(1)) == cols_eff);
	assign stat.have_both = start_ok_q && finish_ok_q;
	assign stat.clr_last  = (clr_q == {IW{1'b1}});
	assign stat.q_empty   = (head_q == tail_q);
	assign stat.found     = found_q;
	assign stat.nb_in     = nb_in;
	assign stat.k_last    = (k_q == gbpm_pkg::DIR_RIGHT);
	assign stat.nb_hit    = nb_take && (nidx == finish_q);
	assign stat.tr_done   = (tcur_q == start_q);

	assign done      = done_q;
	assign status    = status_q;
	assign read_code = read_code_q;

endmodule
